// ===== hdl/fdtd_pkg.sv =====
// Shared types and constants for the 1-D FDTD field row.
// Used by the cell, the update unit, the top level and the checker.
// No dependencies.
package fdtd_pkg;

	localparam int FIELD_W = 18;
	localparam int DIFF_W  = FIELD_W + 1;
	localparam int RATIO_W = 16;
	localparam int PROD_W  = DIFF_W + RATIO_W;
	localparam int SUM_W   = FIELD_W + 3;
	localparam int IDX_W   = 6;
	localparam int OP_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int FRAC_W  = 15;

	localparam logic [RATIO_W-1:0] COURANT_RESET = 16'd16384;

	localparam logic signed [SUM_W-1:0] FIELD_MAX = 21'sd131071;
	localparam logic signed [SUM_W-1:0] FIELD_MIN = -21'sd131072;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = 35'sd16384;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COURANT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_STEP = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROTATE,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

endpackage

// ===== hdl/fdtd_1d_field_update.sv =====
// Top level of the 1-D FDTD field row: ring of cells, update units, control.
// Depends on fdtd_pkg, fdtd_cell and fdtd_upd.
//
// The field row lives in a ring of NUM_CELLS cells that rotates one position per
// cycle past a single pair of update units sitting at cell 0. A step item rotates
// the whole ring, and further to cover the registered product, before it hands the
// result to the output register; load and read items rotate the whole ring, since
// the addressed cell is written or captured as it passes cell 0; op 3 skips the
// rotation and goes to the output register. Input stall is high from the accepting edge
// until that result sits in the output register, which then waits for the
// receiver while the next item is accepted. Configuration writes are always
// accepted (cfg_ready is high) and must only be made while no item is in flight.
module fdtd_1d_field_update #(
	parameter int NUM_CELLS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [fdtd_pkg::OP_W-1:0]        op,
	input  logic [fdtd_pkg::IDX_W-1:0]       cell_index,
	input  logic signed [fdtd_pkg::FIELD_W-1:0] electric_in,
	input  logic signed [fdtd_pkg::FIELD_W-1:0] magnetic_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [fdtd_pkg::FIELD_W-1:0] electric_out,
	output logic signed [fdtd_pkg::FIELD_W-1:0] magnetic_out,
	output logic                             saturated,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fdtd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fdtd_pkg::RATIO_W-1:0]     cfg_data
);
	import fdtd_pkg::*;

	localparam int CNT_W = $clog2(NUM_CELLS + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CELLS - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_CELLS);

	state_t state_q, state_d;

	logic [RATIO_W-1:0] courant_q;
	logic               boundary_q;

	logic [CNT_W-1:0]   cnt_q;
	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	field_t             ein_q, hin_q;
	field_t             rd_e_q, rd_h_q;
	logic               sat_q;
	field_t             prev_e_q, prev_h_q;
	field_t             save_e_q, save_h_q;
	logic               vld_s1, zero_s1;

	logic               out_valid_q;
	field_t             e_out_q, h_out_q;
	logic               sat_out_q;

	field_t             cell_e [NUM_CELLS];
	field_t             cell_h [NUM_CELLS];
	field_t             tail_e, tail_h;
	logic               shift;
	logic               accept;
	logic               out_load;
	logic               match;
	logic               is_first, is_last, is_edge;

	field_t             em1, ep1, hm1, hp1;
	diff_t              diff_e, diff_h;
	field_t             new_e, new_h;
	logic               sat_e, sat_h;

	// ring of cells, cell 0 at the head, tail fed by control
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		if (i == NUM_CELLS - 1) begin : g_tail
			fdtd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.e_next (tail_e),
				.h_next (tail_h),
				.e      (cell_e[i]),
				.h      (cell_h[i])
			);
		end else begin : g_body
			fdtd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.e_next (cell_e[i+1]),
				.h_next (cell_h[i+1]),
				.e      (cell_e[i]),
				.h      (cell_h[i])
			);
		end
	end

	// neighbors of the cell at the head; the edges see the row's wrap cells
	assign is_first = (cnt_q == '0);
	assign is_last  = (cnt_q == CNT_LAST);
	assign is_edge  = is_first || is_last;
	assign em1 = is_first ? cell_e[NUM_CELLS-2] : prev_e_q;
	assign hm1 = is_first ? cell_h[NUM_CELLS-2] : prev_h_q;
	assign ep1 = is_last ? save_e_q : cell_e[1];
	assign hp1 = is_last ? save_h_q : cell_h[1];
	assign diff_h = DIFF_W'(hm1) - DIFF_W'(hp1);
	assign diff_e = DIFF_W'(em1) - DIFF_W'(ep1);

	fdtd_upd u_upd_e (
		.clk    (clk),
		.ratio  (courant_q),
		.old    (cell_e[0]),
		.diff   (diff_h),
		.result (new_e),
		.sat    (sat_e)
	);

	fdtd_upd u_upd_h (
		.clk    (clk),
		.ratio  (courant_q),
		.old    (cell_h[0]),
		.diff   (diff_e),
		.result (new_h),
		.sat    (sat_h)
	);

	assign match  = (CMP_W'(cnt_q) == CMP_W'(idx_q));
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		shift    = 1'b0;
		tail_e   = cell_e[0];
		tail_h   = cell_h[0];
		out_load = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (op_t'(op))
						OP_LOAD, OP_READ: state_d = ST_ROTATE;
						OP_STEP:          state_d = ST_STEP;
						default:          state_d = ST_DONE;
					endcase
				end
			end
			ST_ROTATE: begin
				shift = 1'b1;
				if (op_q == OP_LOAD && match) begin
					tail_e = ein_q;
					tail_h = hin_q;
				end
				if (is_last) begin
					state_d = ST_DONE;
				end
			end
			ST_STEP: begin
				shift  = 1'b1;
				tail_e = zero_s1 ? '0 : new_e;
				tail_h = zero_s1 ? '0 : new_h;
				if (cnt_q == CNT_END) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q  <= COURANT_RESET;
			boundary_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_COURANT) begin
				courant_q <= cfg_data;
			end
			if (cfg_index == REG_BOUNDARY) begin
				boundary_q <= cfg_data[0];
			end
		end
	end

	// sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			zero_s1 <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			vld_s1  <= (state_q == ST_STEP) && (cnt_q != CNT_END);
			zero_s1 <= boundary_q && is_edge;
			if (accept) begin
				cnt_q <= '0;
				sat_q <= 1'b0;
			end else if (shift) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_STEP && vld_s1 && !zero_s1 && (sat_e || sat_h)) begin
				sat_q <= 1'b1;
			end
		end
	end

	// item payload, neighbor history and read capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(op);
			idx_q  <= cell_index;
			ein_q  <= electric_in;
			hin_q  <= magnetic_in;
			rd_e_q <= '0;
			rd_h_q <= '0;
		end else if (state_q == ST_ROTATE && op_q == OP_READ && match) begin
			rd_e_q <= cell_e[0];
			rd_h_q <= cell_h[0];
		end
		if (state_q == ST_STEP) begin
			prev_e_q <= cell_e[0];
			prev_h_q <= cell_h[0];
			if (is_first) begin
				save_e_q <= cell_e[1];
				save_h_q <= cell_h[1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			e_out_q   <= rd_e_q;
			h_out_q   <= rd_h_q;
			sat_out_q <= sat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign electric_out = e_out_q;
	assign magnetic_out = h_out_q;
	assign saturated    = sat_out_q;

endmodule

// ===== hdl/fdtd_cell.sv =====
// One cell of the field ring: holds an electric and a magnetic value.
// Takes its neighbor's pair on every shift. Depends on fdtd_pkg.
module fdtd_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  fdtd_pkg::field_t e_next,
	input  fdtd_pkg::field_t h_next,
	output fdtd_pkg::field_t e,
	output fdtd_pkg::field_t h
);
	import fdtd_pkg::*;

	field_t e_q;
	field_t h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
			h_q <= '0;
		end else if (shift) begin
			e_q <= e_next;
			h_q <= h_next;
		end
	end

	assign e = e_q;
	assign h = h_q;

endmodule

// ===== hdl/fdtd_upd.sv =====
// Field update unit: old + round(ratio * diff), saturated to Q2.15.
// Product registered in the first stage, round and clamp after it. Depends on fdtd_pkg.
module fdtd_upd (
	input  logic                           clk,
	input  logic [fdtd_pkg::RATIO_W-1:0]   ratio,
	input  fdtd_pkg::field_t               old,
	input  fdtd_pkg::diff_t                diff,
	output fdtd_pkg::field_t               result,
	output logic                           sat
);
	import fdtd_pkg::*;

	logic signed [RATIO_W:0]   ratio_s;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s1;
	field_t                    old_s1;
	logic signed [PROD_W-1:0]  rounded;
	logic signed [SUM_W-1:0]   incr;
	logic signed [SUM_W-1:0]   sum;

	assign ratio_s = $signed({1'b0, ratio});
	assign prod    = diff * ratio_s;

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		old_s1  <= old;
	end

	// floor after adding half rounds ties up
	assign rounded = prod_s1 + ROUND_HALF;
	assign incr    = SUM_W'(rounded >>> FRAC_W);
	assign sum     = SUM_W'(old_s1) + incr;

	always_comb begin
		sat    = 1'b0;
		result = FIELD_W'(sum);
		if (sum > FIELD_MAX) begin
			sat    = 1'b1;
			result = FIELD_W'(FIELD_MAX);
		end else if (sum < FIELD_MIN) begin
			sat    = 1'b1;
			result = FIELD_W'(FIELD_MIN);
		end
	end

endmodule

// ===== hdl/fdtd_chk.sv =====
// Port-level checks for the FDTD field row, bound to the top level.
// Depends on fdtd_pkg and fdtd_1d_field_update.
module fdtd_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [fdtd_pkg::FIELD_W-1:0] electric_out,
	input logic signed [fdtd_pkg::FIELD_W-1:0] magnetic_out,
	input logic                                saturated
);
	import fdtd_pkg::*;

	// a held result must stay
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(electric_out) && $stable(saturated))
		else $error("stalled result changed or dropped");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous one in flight");

	// only a step flags saturation, and a step returns zero fields
	a_sat_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> electric_out == '0 && magnetic_out == '0)
		else $error("saturation flag with nonzero fields");

	// a new result only appears after the block was busy
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

endmodule

bind fdtd_1d_field_update fdtd_chk u_chk (.*);

// ===== verif/fdtd_checker.sv =====
// Checker for the 1-D FDTD field row: watches the item, result and register channels.
// Keeps its own copy of the field row and registers, predicts each result, compares.
// Depends on fdtd_pkg.
module fdtd_checker #(
	parameter int NUM_CELLS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [fdtd_pkg::OP_W-1:0]           op,
	input  logic [fdtd_pkg::IDX_W-1:0]          cell_index,
	input  logic signed [fdtd_pkg::FIELD_W-1:0] electric_in,
	input  logic signed [fdtd_pkg::FIELD_W-1:0] magnetic_in,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [fdtd_pkg::FIELD_W-1:0] electric_out,
	input  logic signed [fdtd_pkg::FIELD_W-1:0] magnetic_out,
	input  logic                                saturated,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [fdtd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fdtd_pkg::RATIO_W-1:0]        cfg_data,
	output int                                  outstanding,
	output int                                  fail_count
);
	import fdtd_pkg::*;

	typedef struct {
		field_t electric;
		field_t magnetic;
		logic   sat;
	} cell_result_t;

	logic [RATIO_W-1:0] courant;
	logic               fixed_edges;
	field_t             e_row [NUM_CELLS];
	field_t             h_row [NUM_CELLS];
	cell_result_t       row_results_q [$];

	// old value plus the rounded scaled difference, clamped to Q2.15
	function automatic field_t scale_add(field_t old_v, diff_t diff, inout logic sat);
		longint prod;
		longint sum;
		prod = longint'(courant) * longint'(diff);
		sum  = longint'(old_v) + ((prod + 64'sd16384) >>> FRAC_W);
		if (sum > longint'(FIELD_MAX)) begin
			sat = 1'b1;
			return field_t'(FIELD_MAX);
		end
		if (sum < longint'(FIELD_MIN)) begin
			sat = 1'b1;
			return field_t'(FIELD_MIN);
		end
		return field_t'(sum);
	endfunction

	// advance the whole row one time step from the old values
	function automatic logic advance_row();
		field_t ne [NUM_CELLS];
		field_t nh [NUM_CELLS];
		diff_t  dh;
		diff_t  de;
		logic   sat;
		sat = 1'b0;
		for (int k = 1; k < NUM_CELLS - 1; k++) begin
			ne[k] = scale_add(e_row[k], diff_t'(h_row[k-1]) - diff_t'(h_row[k+1]), sat);
			nh[k] = scale_add(h_row[k], diff_t'(e_row[k-1]) - diff_t'(e_row[k+1]), sat);
		end
		if (!fixed_edges) begin
			// both edges wrap to the same pair of neighbours
			dh = diff_t'(h_row[NUM_CELLS-2]) - diff_t'(h_row[1]);
			de = diff_t'(e_row[NUM_CELLS-2]) - diff_t'(e_row[1]);
			ne[0]           = scale_add(e_row[0], dh, sat);
			ne[NUM_CELLS-1] = scale_add(e_row[NUM_CELLS-1], dh, sat);
			nh[0]           = scale_add(h_row[0], de, sat);
			nh[NUM_CELLS-1] = scale_add(h_row[NUM_CELLS-1], de, sat);
		end else begin
			ne[0]           = '0;
			ne[NUM_CELLS-1] = '0;
			nh[0]           = '0;
			nh[NUM_CELLS-1] = '0;
		end
		e_row = ne;
		h_row = nh;
		return sat;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		int           errs;
		if (!arst_n) begin
			courant     = COURANT_RESET;
			fixed_edges = 1'b0;
			for (int k = 0; k < NUM_CELLS; k++) begin
				e_row[k] = '0;
				h_row[k] = '0;
			end
			row_results_q.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COURANT:  courant = cfg_data;
					REG_BOUNDARY: fixed_edges = cfg_data[0];
					default: ;
				endcase
			end

			// compare before predicting: a result never leaves on its own item's edge
			if (out_valid && !out_stall) begin
				if (row_results_q.size() == 0) begin
					$display("%0t: result with nothing expected: e=%0d h=%0d sat=%0b",
						$time, electric_out, magnetic_out, saturated);
					errs++;
				end else begin
					want = row_results_q.pop_front();
					if (electric_out !== want.electric) begin
						$display("%0t: electric_out expected %0d actual %0d",
							$time, want.electric, electric_out);
						errs++;
					end
					if (magnetic_out !== want.magnetic) begin
						$display("%0t: magnetic_out expected %0d actual %0d",
							$time, want.magnetic, magnetic_out);
						errs++;
					end
					if (saturated !== want.sat) begin
						$display("%0t: saturated expected %0b actual %0b",
							$time, want.sat, saturated);
						errs++;
					end
				end
			end

			if (in_valid && !in_stall) begin
				want.electric = '0;
				want.magnetic = '0;
				want.sat      = 1'b0;
				case (op)
					OP_LOAD: begin
						if (cell_index < NUM_CELLS) begin
							e_row[cell_index] = electric_in;
							h_row[cell_index] = magnetic_in;
						end
					end
					OP_STEP: want.sat = advance_row();
					OP_READ: begin
						if (cell_index < NUM_CELLS) begin
							want.electric = e_row[cell_index];
							want.magnetic = h_row[cell_index];
						end
					end
					default: ;
				endcase
				row_results_q.push_back(want);
			end

			fail_count  <= fail_count + errs;
			outstanding <= row_results_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the FDTD field row testbench: clock, reset, item and register stimulus, verdict.
// Depends on fdtd_pkg, fdtd_1d_field_update and fdtd_checker.
module testbench;
	import fdtd_pkg::*;

	localparam int NUM_CELLS   = 64;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 205;
	localparam int PHASE_LOADS = 24;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN       = 2 * NUM_CELLS + 8;
	localparam int CYCLE_LIMIT = 800000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [IDX_W-1:0]    cell_index;
	field_t              electric_in;
	field_t              magnetic_in;
	logic                out_valid;
	logic                out_stall;
	field_t              electric_out;
	field_t              magnetic_out;
	logic                saturated;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RATIO_W-1:0]  cfg_data;
	int                  outstanding;
	int                  fail_count;
	logic                quiet = 1'b0;
	logic                long_hold_req = 1'b0;
	int                  cycles = 0;

	always #2 clk = ~clk;

	fdtd_1d_field_update #(.NUM_CELLS(NUM_CELLS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .cell_index(cell_index),
		.electric_in(electric_in), .magnetic_in(magnetic_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.electric_out(electric_out), .magnetic_out(magnetic_out), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	fdtd_checker #(.NUM_CELLS(NUM_CELLS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .cell_index(cell_index),
		.electric_in(electric_in), .magnetic_in(magnetic_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.electric_out(electric_out), .magnetic_out(magnetic_out), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.outstanding(outstanding), .fail_count(fail_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("fdtd_1d_field_update regression: fail");
			$finish;
		end
	end

	// result side: short random stall bursts, one long hold-off on request
	initial begin
		int  stall_left;
		bit  long_hold_done;
		stall_left     = 0;
		long_hold_done = 1'b0;
		out_stall     <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (long_hold_req && !long_hold_done) begin
				long_hold_done = 1'b1;
				stall_left     = LONG_HOLD - 1;
				out_stall     <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic field_t pick_field();
		case ($urandom_range(0, 3))
			0: return field_t'(int'($urandom_range(0, 8191)) - 4096);
			1: begin
				case ($urandom_range(0, 3))
					0: return field_t'(FIELD_MAX);
					1: return field_t'(FIELD_MIN);
					2: return '0;
					default: return '1;
				endcase
			end
			default: return field_t'($urandom());
		endcase
	endfunction

	// offer one item, return at the edge that takes it
	task automatic send_item(input logic [OP_W-1:0] code, input logic [IDX_W-1:0] idx,
		input field_t e_val, input field_t h_val);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= code;
		cell_index  <= idx;
		electric_in <= e_val;
		magnetic_in <= h_val;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			send_item(OP_LOAD, IDX_W'($urandom()), pick_field(), pick_field());
		else if (pick < 60)
			send_item(OP_STEP, IDX_W'($urandom()), pick_field(), pick_field());
		else if (pick < 95)
			send_item(OP_READ, IDX_W'($urandom()), pick_field(), pick_field());
		else
			send_item(OP_UNUSED, IDX_W'($urandom()), pick_field(), pick_field());
	endtask

	// drop valid and hold until every result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [RATIO_W-1:0] ratio;
		logic               edges;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_LOAD;
		cell_index  = '0;
		electric_in = '0;
		magnetic_in = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_COURANT;
		cfg_data    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: edge cells, field extremes, every op, saturation, at reset settings
		send_item(OP_LOAD, 6'd0, field_t'(FIELD_MAX), field_t'(FIELD_MIN));
		send_item(OP_LOAD, 6'd63, field_t'(FIELD_MIN), field_t'(FIELD_MAX));
		send_item(OP_LOAD, 6'd1, '1, field_t'(FIELD_MAX));
		send_item(OP_LOAD, 6'd2, field_t'(FIELD_MAX), '0);
		send_item(OP_LOAD, 6'd3, '0, field_t'(FIELD_MIN));
		send_item(OP_LOAD, 6'd62, '0, '1);
		send_item(OP_LOAD, 6'd31, field_t'(FIELD_MAX), field_t'(FIELD_MAX));
		send_item(OP_READ, 6'd0, '1, '1);
		send_item(OP_READ, 6'd63, '0, '0);
		send_item(OP_UNUSED, 6'd63, field_t'(FIELD_MAX), field_t'(FIELD_MIN));
		send_item(OP_READ, 6'd63, '0, '0);
		send_item(OP_STEP, 6'd0, '0, '0);
		send_item(OP_READ, 6'd0, '0, '0);
		send_item(OP_READ, 6'd1, '0, '0);
		send_item(OP_READ, 6'd2, '0, '0);
		send_item(OP_READ, 6'd62, '0, '0);
		send_item(OP_READ, 6'd63, '0, '0);
		send_item(OP_STEP, 6'd63, field_t'(FIELD_MIN), field_t'(FIELD_MAX));
		send_item(OP_READ, 6'd2, '0, '0);
		send_item(OP_READ, 6'd31, '0, '0);
		send_item(OP_READ, 6'd63, '0, '0);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin ratio = 16'd0;     edges = 1'b0; end
				1: begin ratio = 16'd32768; edges = 1'b1; end
				2: begin ratio = 16'd65535; edges = 1'b0; end
				3: begin ratio = 16'd1;     edges = 1'b1; end
				4: begin ratio = 16'd16384; edges = 1'b1; end
				5: begin ratio = RATIO_W'($urandom()); edges = 1'b0; end
				6: begin
					ratio = RATIO_W'($urandom_range(0, 32768));
					edges = 1'($urandom_range(0, 1));
				end
				default: begin ratio = 16'd32768; edges = 1'b0; end
			endcase
			wait_idle();
			write_reg(REG_COURANT, ratio);
			write_reg(REG_BOUNDARY, {{(RATIO_W-1){1'b0}}, edges});
			if (phase == NUM_PHASES - 1)
				quiet <= 1'b1;
			if (phase == 2)
				long_hold_req <= 1'b1;
			// seed the row with fresh values, then mix
			for (int n = 0; n < PHASE_LOADS; n++)
				send_item(OP_LOAD, IDX_W'($urandom()), pick_field(), pick_field());
			for (int n = PHASE_LOADS; n < PHASE_ITEMS; n++)
				random_item();
		end

		wait_idle();
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("fdtd_1d_field_update regression: pass");
		else
			$display("fdtd_1d_field_update regression: fail");
		$finish;
	end

endmodule
